>>> design/lce_range_min_query_defines.svh
// Assertion macros for the LCE range-minimum query block.
// Included by design/lce_range_min_query.sv; no other dependencies.
`ifndef LCE_RANGE_MIN_QUERY_DEFINES_SVH
`define LCE_RANGE_MIN_QUERY_DEFINES_SVH

// same-cycle implication
`define LRMQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lrmq same-cycle check failed");

// next-cycle implication
`define LRMQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lrmq next-cycle check failed");

`endif

>>> design/lrmq_pkg.sv
// Shared types and codes for the LCE range-minimum query block.
// No dependencies; used by design/lce_range_min_query.sv.
package lrmq_pkg;

	localparam int LCPW  = 11;
	localparam int RANKW = 10;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_QUERY = 2'd1;
	localparam logic [1:0] OP_BUILD = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_QRANK,
		ST_QDIV,
		ST_QADR,
		ST_QROW,
		ST_QLCP,
		ST_QFIN,
		ST_BRD,
		ST_BUPD,
		ST_SRD,
		ST_SWR
	} state_t;

endpackage

>>> design/lce_range_min_query.sv
// Longest-common-extension queries over a loaded rank/LCP index.
// Load: never busy. Query: result strobe in the cycle after accept for out-of-range
// or equal positions, registered from ST_QRANK for equal/out-of-range ranks, else from ST_QFIN
// after a chain of rank, block-row/sparse-table, block-min and LCP memory reads. Build: busy
// while it reads each LCP entry, then fills the sparse table over nb = ceil(len/BLOCK_SIZE) blocks.
// Reset: async active low; idle, length register 1024, nothing built (queries out of range).
// Depends on lrmq_pkg and lce_range_min_query_defines.svh.
`include "lce_range_min_query_defines.svh"

module lce_range_min_query #(
	parameter int MAX_LENGTH = 1024,
	parameter int BLOCK_SIZE = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [10:0] cfg_wr_data,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [9:0]  position,
	input  logic [9:0]  rank_value,
	input  logic [10:0] lcp_value,
	input  logic [9:0]  second_position,
	output logic        done,
	output logic [10:0] extension_length,
	output logic        out_of_range
);

	localparam int LCPW  = lrmq_pkg::LCPW;
	localparam int RANKW = lrmq_pkg::RANKW;
	localparam int PW    = MAX_LENGTH > 1 ? $clog2(MAX_LENGTH) : 1;
	localparam int LW    = $clog2(MAX_LENGTH + 1);
	localparam int NB    = (MAX_LENGTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
	localparam int NBW   = NB > 1 ? $clog2(NB) : 1;
	localparam int OW    = BLOCK_SIZE > 1 ? $clog2(BLOCK_SIZE) : 1;
	localparam int QPB   = (BLOCK_SIZE * (BLOCK_SIZE + 1)) / 2;
	localparam int SLW   = QPB > 1 ? $clog2(QPB) : 1;
	localparam int LVW   = $clog2(NBW + 1);
	localparam int TAW   = LVW + NBW;
	localparam int TW    = NBW + LCPW;
	localparam int SH    = PW + 1;
	localparam int RECIP = (2 ** SH) / BLOCK_SIZE;
	localparam int PRW   = PW + SH + 1;

	// slot of in-block range [s..e]
	function automatic logic [SLW-1:0] slot_of(input logic [OW-1:0] s, input logic [OW-1:0] e);
		int si;
		int ei;
		si = int'(s);
		ei = int'(e);
		return SLW'(si * BLOCK_SIZE - (si * si - si) / 2 + (ei - si));
	endfunction

	function automatic logic [LVW-1:0] flog2(input logic [NBW:0] v);
		logic [LVW-1:0] r;
		r = '0;
		for (int b = 1; b <= NBW; b++) begin
			if (v[b]) r = LVW'(b);
		end
		return r;
	endfunction

	// memories
	logic [RANKW-1:0]     rank_mem [1<<PW];
	logic [LCPW-1:0]      lcp_mem  [1<<PW];
	logic [QPB*OW-1:0]    iba_mem  [1<<NBW];
	logic [PW-1:0]        bmin_mem [1<<NBW];
	logic [TW-1:0]        tbl_mem  [1<<TAW];

	logic [RANKW-1:0]  rank_rda_q, rank_rdb_q;
	logic [LCPW-1:0]   lcp_rda_q, lcp_rdb_q;
	logic [QPB*OW-1:0] iba_rda_q, iba_rdb_q;
	logic [PW-1:0]     bmin_rda_q, bmin_rdb_q;
	logic [TW-1:0]     tbl_rda_q, tbl_rdb_q;

	logic [PW-1:0]     lcp_ra, lcp_rb;
	logic [NBW-1:0]    iba_ra, iba_rb, bmin_ra, bmin_rb;
	logic [TAW-1:0]    tbl_ra, tbl_rb, tbl_wa;
	logic [TW-1:0]     tbl_wd;
	logic              blk_we, tbl_we, load_we;

	// control and result registers
	lrmq_pkg::state_t  state_q, state_d;
	logic [10:0]       text_length_q;
	logic [LW-1:0]     built_len_q;
	logic              done_q, done_d, oor_q, oor_d;
	logic [LCPW-1:0]   ext_q, ext_d;

	// datapath registers
	logic [PW-1:0]     lo_q, hi_q;
	logic [NBW-1:0]    qlo_q, qhi_q, bi_q, bj_q;
	logic [OW-1:0]     ip_q, jp_q;
	logic              same_q, far_q;
	logic [LCPW-1:0]   vmn_q;
	logic [PW-1:0]     p_q, base_q;
	logic [OW-1:0]     o_q;
	logic [NBW-1:0]    b_q, si_q;
	logic [NBW:0]      nb_q;
	logic [LVW-1:0]    d_q, lvl_q;
	logic [QPB*OW-1:0] row_q;
	logic [OW-1:0]     m_q [BLOCK_SIZE];
	logic [LCPW-1:0]   v_q [BLOCK_SIZE];

	logic acc, load_acc, building;
	assign acc  = start && (state_q == lrmq_pkg::ST_IDLE);
	assign busy = state_q != lrmq_pkg::ST_IDLE;
	assign done = done_q;
	assign extension_length = ext_q;
	assign out_of_range = oor_q;
	assign load_acc = acc && opcode == lrmq_pkg::OP_LOAD;
	assign load_we  = load_acc && int'(position) < MAX_LENGTH;
	assign building = state_q inside {lrmq_pkg::ST_BRD, lrmq_pkg::ST_BUPD,
		lrmq_pkg::ST_SRD, lrmq_pkg::ST_SWR};

	// query helpers
	logic              pos_oor;
	logic [RANKW:0]    lo_w, hi_w;
	logic              rank_bad;
	logic [PRW-1:0]    lo_prod, hi_prod;
	logic [PW:0]       lo_rem, hi_rem;
	logic [NBW-1:0]    q_l, q_r, q_dd, q_y;
	logic [LVW-1:0]    q_k;
	logic              q_far, q_pair;
	logic [SLW-1:0]    sl_a, sl_b;
	logic [OW-1:0]     off_a, off_b;
	logic [PW-1:0]     mi, mj;
	logic [LCPW-1:0]   vmn, vc, res_v;

	assign pos_oor = int'(position) >= int'(built_len_q)
		|| int'(second_position) >= int'(built_len_q);
	assign lo_w = (rank_rda_q < rank_rdb_q) ? (RANKW+1)'(rank_rda_q) + 1'b1
		: (RANKW+1)'(rank_rdb_q) + 1'b1;
	assign hi_w = (rank_rda_q < rank_rdb_q) ? (RANKW+1)'(rank_rdb_q) : (RANKW+1)'(rank_rda_q);
	assign rank_bad = rank_rda_q == rank_rdb_q || int'(hi_w) >= int'(built_len_q);
	assign lo_prod = PRW'(PW'(lo_w)) * PRW'(RECIP);
	assign hi_prod = PRW'(PW'(hi_w)) * PRW'(RECIP);
	assign lo_rem = (PW+1)'(lo_q) - (PW+1)'(qlo_q) * (PW+1)'(BLOCK_SIZE);
	assign hi_rem = (PW+1)'(hi_q) - (PW+1)'(qhi_q) * (PW+1)'(BLOCK_SIZE);
	assign q_l = bi_q + 1'b1;
	assign q_r = bj_q - 1'b1;
	assign q_dd = q_r - q_l;
	assign q_k = flog2((NBW+1)'(q_dd));
	assign q_y = NBW'((NBW+1)'(q_r) + 1'b1 - ((NBW+1)'(1) << q_k));
	assign q_far = (NBW+1)'(bj_q) > (NBW+1)'(bi_q) + 1'b1;
	// two middle blocks: take the pair winner stored at build time
	assign q_pair = q_dd == NBW'(1);
	assign sl_a = same_q ? slot_of(ip_q, jp_q) : slot_of(ip_q, OW'(BLOCK_SIZE - 1));
	assign sl_b = slot_of('0, jp_q);
	assign off_a = iba_rda_q[int'(sl_a) * OW +: OW];
	assign off_b = iba_rdb_q[int'(sl_b) * OW +: OW];
	assign mi = PW'(bi_q * BLOCK_SIZE) + PW'(off_a);
	assign mj = PW'(bj_q * BLOCK_SIZE) + PW'(off_b);
	assign vmn = (same_q || lcp_rda_q < lcp_rdb_q) ? lcp_rda_q : lcp_rdb_q;
	assign vc = (lcp_rda_q <= lcp_rdb_q) ? lcp_rda_q : lcp_rdb_q;
	assign res_v = (far_q && vc < vmn_q) ? vc : vmn_q;

	// build helpers
	logic [LW-1:0]     len_sat;
	logic              blk_end, p_last;
	logic [NBW:0]      nb_new, s_ib;
	logic [QPB*OW-1:0] row_new;
	logic [OW-1:0]     m_new [BLOCK_SIZE];
	logic [LCPW-1:0]   v_new [BLOCK_SIZE];
	logic              s_hasb, s_last;
	logic [TW-1:0]     s_win;

	assign len_sat = (int'(text_length_q) > MAX_LENGTH) ? LW'(MAX_LENGTH) : LW'(text_length_q);
	assign p_last  = int'(p_q) + 1 == int'(built_len_q);
	assign blk_end = o_q == OW'(BLOCK_SIZE - 1) || p_last;
	assign nb_new  = (NBW+1)'(b_q) + 1'b1;
	assign s_ib    = (NBW+1)'(si_q) + ((NBW+1)'(1) << (lvl_q - 1'b1));
	assign s_hasb  = s_ib < nb_q;
	assign s_last  = (NBW+1)'(si_q) + 1'b1 == nb_q;
	assign s_win   = (s_hasb && tbl_rdb_q[LCPW-1:0] < tbl_rda_q[LCPW-1:0]) ? tbl_rdb_q
		: tbl_rda_q;

	// running in-block minima per start offset
	always_comb begin
		row_new = row_q;
		for (int j = 0; j < BLOCK_SIZE; j++) begin
			m_new[j] = m_q[j];
			v_new[j] = v_q[j];
			if (OW'(j) == o_q) begin
				m_new[j] = o_q;
				v_new[j] = lcp_rda_q;
			end else if (OW'(j) < o_q && lcp_rda_q < v_q[j]) begin
				m_new[j] = o_q;
				v_new[j] = lcp_rda_q;
			end
			if (OW'(j) <= o_q) row_new[int'(slot_of(OW'(j), o_q)) * OW +: OW] = m_new[j];
		end
	end

	// next state, results, memory ports
	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		ext_d   = ext_q;
		oor_d   = oor_q;
		lcp_ra  = '0;
		lcp_rb  = '0;
		iba_ra  = bi_q;
		iba_rb  = bj_q;
		bmin_ra = tbl_rda_q[TW-1:LCPW];
		bmin_rb = tbl_rdb_q[TW-1:LCPW];
		tbl_ra  = q_pair ? {LVW'(1), q_l} : {q_k, q_l};
		tbl_rb  = q_pair ? {LVW'(1), q_l} : {q_k, q_y};
		tbl_wa  = {lvl_q, si_q};
		tbl_wd  = s_win;
		blk_we  = 1'b0;
		tbl_we  = 1'b0;
		case (state_q)
			lrmq_pkg::ST_IDLE: begin
				if (acc && opcode == lrmq_pkg::OP_QUERY) begin
					if (pos_oor) begin
						done_d = 1'b1;
						ext_d  = '0;
						oor_d  = 1'b1;
					end else if (position == second_position) begin
						done_d = 1'b1;
						ext_d  = LCPW'(int'(built_len_q) - int'(position));
						oor_d  = 1'b0;
					end else begin
						state_d = lrmq_pkg::ST_QRANK;
					end
				end else if (acc && opcode == lrmq_pkg::OP_BUILD) begin
					if (len_sat != '0) state_d = lrmq_pkg::ST_BRD;
				end
			end
			lrmq_pkg::ST_QRANK: begin
				if (rank_bad) begin
					done_d  = 1'b1;
					ext_d   = '0;
					oor_d   = 1'b0;
					state_d = lrmq_pkg::ST_IDLE;
				end else begin
					state_d = lrmq_pkg::ST_QDIV;
				end
			end
			lrmq_pkg::ST_QDIV: state_d = lrmq_pkg::ST_QADR;
			lrmq_pkg::ST_QADR: state_d = lrmq_pkg::ST_QROW;
			lrmq_pkg::ST_QROW: begin
				lcp_ra  = mi;
				lcp_rb  = mj;
				state_d = lrmq_pkg::ST_QLCP;
			end
			lrmq_pkg::ST_QLCP: begin
				lcp_ra  = bmin_rda_q;
				lcp_rb  = bmin_rdb_q;
				state_d = lrmq_pkg::ST_QFIN;
			end
			lrmq_pkg::ST_QFIN: begin
				done_d  = 1'b1;
				ext_d   = res_v;
				oor_d   = 1'b0;
				state_d = lrmq_pkg::ST_IDLE;
			end
			lrmq_pkg::ST_BRD: begin
				lcp_ra  = p_q;
				state_d = lrmq_pkg::ST_BUPD;
			end
			lrmq_pkg::ST_BUPD: begin
				blk_we = blk_end;
				tbl_we = blk_end;
				tbl_wa = {LVW'(0), b_q};
				tbl_wd = {b_q, v_new[0]};
				if (!p_last) state_d = lrmq_pkg::ST_BRD;
				else if (flog2(nb_new) == '0) state_d = lrmq_pkg::ST_IDLE;
				else state_d = lrmq_pkg::ST_SRD;
			end
			lrmq_pkg::ST_SRD: begin
				tbl_ra  = {lvl_q - 1'b1, si_q};
				tbl_rb  = {lvl_q - 1'b1, NBW'(s_ib)};
				state_d = lrmq_pkg::ST_SWR;
			end
			lrmq_pkg::ST_SWR: begin
				tbl_we = 1'b1;
				if (s_last && lvl_q == d_q) state_d = lrmq_pkg::ST_IDLE;
				else state_d = lrmq_pkg::ST_SRD;
			end
			default: state_d = lrmq_pkg::ST_IDLE;
		endcase
	end

	// state, config and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= lrmq_pkg::ST_IDLE;
			text_length_q <= 11'd1024;
			built_len_q   <= '0;
			done_q        <= 1'b0;
			ext_q         <= '0;
			oor_q         <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			ext_q   <= ext_d;
			oor_q   <= oor_d;
			if (cfg_wr_en) text_length_q <= cfg_wr_data;
			if (acc && opcode == lrmq_pkg::OP_BUILD) built_len_q <= len_sat;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			lrmq_pkg::ST_IDLE: begin
				p_q    <= '0;
				o_q    <= '0;
				b_q    <= '0;
				base_q <= '0;
				row_q  <= '0;
			end
			lrmq_pkg::ST_QRANK: begin
				lo_q  <= PW'(lo_w);
				hi_q  <= PW'(hi_w);
				qlo_q <= lo_prod[SH +: NBW];
				qhi_q <= hi_prod[SH +: NBW];
			end
			lrmq_pkg::ST_QDIV: begin
				if (lo_rem >= (PW+1)'(BLOCK_SIZE)) begin
					bi_q <= qlo_q + 1'b1;
					ip_q <= OW'(lo_rem - (PW+1)'(BLOCK_SIZE));
				end else begin
					bi_q <= qlo_q;
					ip_q <= OW'(lo_rem);
				end
				if (hi_rem >= (PW+1)'(BLOCK_SIZE)) begin
					bj_q <= qhi_q + 1'b1;
					jp_q <= OW'(hi_rem - (PW+1)'(BLOCK_SIZE));
				end else begin
					bj_q <= qhi_q;
					jp_q <= OW'(hi_rem);
				end
			end
			lrmq_pkg::ST_QADR: begin
				same_q <= bi_q == bj_q;
				far_q  <= q_far;
			end
			lrmq_pkg::ST_QLCP: vmn_q <= vmn;
			lrmq_pkg::ST_BUPD: begin
				p_q <= p_q + 1'b1;
				m_q <= m_new;
				v_q <= v_new;
				if (blk_end) begin
					o_q    <= '0;
					b_q    <= b_q + 1'b1;
					base_q <= base_q + PW'(BLOCK_SIZE);
					row_q  <= '0;
				end else begin
					o_q   <= o_q + 1'b1;
					row_q <= row_new;
				end
				nb_q  <= nb_new;
				d_q   <= flog2(nb_new);
				lvl_q <= LVW'(1);
				si_q  <= '0;
			end
			lrmq_pkg::ST_SWR: begin
				if (s_last) begin
					si_q  <= '0;
					lvl_q <= lvl_q + 1'b1;
				end else begin
					si_q <= si_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// rank and LCP stores
	always_ff @(posedge clk) begin
		if (load_we) begin
			rank_mem[PW'(position)] <= rank_value;
			lcp_mem[PW'(position)]  <= lcp_value;
		end
		rank_rda_q <= rank_mem[PW'(position)];
		rank_rdb_q <= rank_mem[PW'(second_position)];
		lcp_rda_q  <= lcp_mem[lcp_ra];
		lcp_rdb_q  <= lcp_mem[lcp_rb];
	end

	// per-block rows and block minimum positions
	always_ff @(posedge clk) begin
		if (blk_we) begin
			iba_mem[b_q]  <= row_new;
			bmin_mem[b_q] <= base_q + PW'(m_new[0]);
		end
		iba_rda_q  <= iba_mem[iba_ra];
		iba_rdb_q  <= iba_mem[iba_rb];
		bmin_rda_q <= bmin_mem[bmin_ra];
		bmin_rdb_q <= bmin_mem[bmin_rb];
	end

	// sparse table over blocks, level 0 is the blocks themselves
	always_ff @(posedge clk) begin
		if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
		tbl_rda_q <= tbl_mem[tbl_ra];
		tbl_rdb_q <= tbl_mem[tbl_rb];
	end

	`LRMQ_ASSERT_IMP(a_oor_zero, clk, arst_n, done && out_of_range, extension_length == '0)
	`LRMQ_ASSERT_NXT(a_load_quiet, clk, arst_n, load_acc, state_q == lrmq_pkg::ST_IDLE && !done)
	`LRMQ_ASSERT_IMP(a_build_quiet, clk, arst_n, building, !done)
	`LRMQ_ASSERT_NXT(a_fin_done, clk, arst_n, state_q == lrmq_pkg::ST_QFIN, done && !busy)

endmodule
